/* hdl/contiguous_core_allocator_defines.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the contiguous core allocator
// Shared property forms for the checker.
// ----------------------------------------------------------------------------
`ifndef CONTIGUOUS_CORE_ALLOCATOR_DEFINES_SVH
`define CONTIGUOUS_CORE_ALLOCATOR_DEFINES_SVH

// same-cycle implication
`define CCA_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define CCA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hdl/cca_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cca_pkg
// Codes, limits and defaults shared by the core allocator and its checker.
// ----------------------------------------------------------------------------
package cca_pkg;

    localparam int CCA_MAX_NUMA            = 4;
    localparam int CCA_MAX_GROUPS_PER_NUMA = 8;
    localparam int CCA_MAX_CORES_PER_GROUP = 64;
    localparam int CCA_SLOT_COUNT          = 256;
    localparam int CCA_KEY_BYTES           = 8;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 8;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_NUMA_COUNT       = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GROUPS_PER_NUMA  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CORES_PER_GROUP  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SMT_ON           = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SMT_PROTECT      = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_MEMORY_PER_GROUP = 3'd5;

    // register reset values
    localparam logic [2:0] RST_NUMA_COUNT       = 3'd2;
    localparam logic [3:0] RST_GROUPS_PER_NUMA  = 4'd4;
    localparam logic [5:0] RST_CORES_PER_GROUP  = 6'd8;
    localparam logic       RST_SMT_ON           = 1'b1;
    localparam logic       RST_SMT_PROTECT      = 1'b0;
    localparam logic [7:0] RST_MEMORY_PER_GROUP = 8'd64;

    localparam logic [7:0] SHARED_LIMIT = 8'd24;
    localparam logic [7:0] ODD_BIT      = 8'h01;

    localparam logic OP_REQUEST   = 1'b0;
    localparam logic OP_RELEASE   = 1'b1;
    localparam logic KIND_EXCL    = 1'b0;
    localparam logic KIND_RESERVE = 1'b1;

    typedef enum logic [3:0] {
        ST_GRANTED   = 4'd0,
        ST_TOO_MANY  = 4'd1,
        ST_MEM_BIG   = 4'd2,
        ST_NO_SLOT   = 4'd3,
        ST_NO_FIT    = 4'd4,
        ST_RELEASED  = 4'd5,
        ST_NOT_FOUND = 4'd6,
        ST_SHARED    = 4'd7,
        ST_RES_KEPT  = 4'd8
    } t_status;

    typedef enum logic [1:0] {
        CORE_IDLE     = 2'd0,
        CORE_RESERVED = 2'd1,
        CORE_EXCL     = 2'd2
    } t_core_state;

    typedef enum logic [1:0] {
        SLOT_FREE = 2'd0,
        SLOT_EXCL = 2'd1,
        SLOT_RSVD = 2'd2
    } t_slot_kind;

endpackage

/* hdl/contiguous_core_allocator.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// contiguous_core_allocator
// Grants runs of contiguous idle cores to workloads and frees them by key.
// ----------------------------------------------------------------------------
// One word in gives one word out. The block takes one word at a time. A request
// scans the slot table (one slot per cycle), then visits cache groups round
// robin by node; each group passes through selection (S_GSEL) and check
// (S_GCHK) and, when it qualifies, a core scan through the core state memory,
// one core per cycle. A grant then writes one core per cycle. A release scans
// the slot table and, for an exclusive slot, writes its cores back to idle.
// After reset and after any write to numa_count, groups_per_numa,
// cores_per_group or smt_on the block runs a clearing pass during which
// s_axis_tready stays low.
// ----------------------------------------------------------------------------
module contiguous_core_allocator
    import cca_pkg::*;
#(
    parameter int MAX_NUMA            = CCA_MAX_NUMA,
    parameter int MAX_GROUPS_PER_NUMA = CCA_MAX_GROUPS_PER_NUMA,
    parameter int MAX_CORES_PER_GROUP = CCA_MAX_CORES_PER_GROUP,
    parameter int SLOT_COUNT          = CCA_SLOT_COUNT,
    parameter int KEY_BYTES           = CCA_KEY_BYTES
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // pod_key[63:0], core_ask[71:64], memory_ask[79:72]
    input  logic [79:0]           s_axis_tdata,
    // op[0], request_kind[1]
    input  logic [1:0]            s_axis_tuser,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // pod_slot[7:0], first_core[18:8], core_count[25:19], zero fill above
    output logic [31:0]           m_axis_tdata,
    // status[3:0]
    output logic [3:0]            m_axis_tuser,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata
);

    localparam int TOTAL_GROUPS = MAX_NUMA * MAX_GROUPS_PER_NUMA;
    localparam int TOTAL_CORES  = TOTAL_GROUPS * MAX_CORES_PER_GROUP;
    localparam int NW   = (MAX_NUMA > 1) ? $clog2(MAX_NUMA) : 1;
    localparam int JW   = (MAX_GROUPS_PER_NUMA > 1) ? $clog2(MAX_GROUPS_PER_NUMA) : 1;
    localparam int GW   = (TOTAL_GROUPS > 1) ? $clog2(TOTAL_GROUPS) : 1;
    localparam int KW   = $clog2(MAX_CORES_PER_GROUP);
    localparam int VW   = $clog2(MAX_CORES_PER_GROUP + 1);
    localparam int CAW  = $clog2(TOTAL_CORES);
    localparam int SW   = $clog2(SLOT_COUNT);
    localparam int KB   = 8 * KEY_BYTES;
    localparam int CLR_N = (TOTAL_CORES > SLOT_COUNT) ? TOTAL_CORES : SLOT_COUNT;
    localparam int CLRW = $clog2(CLR_N + 1);
    localparam int SYW  = NW + 5;
    localparam int PW   = SYW + VW;

    typedef struct packed {
        t_slot_kind       kind;
        logic [KB-1:0]    key;
        logic [NW-1:0]    n;
        logic [JW-1:0]    j;
        logic [KW-1:0]    k;
        logic [VW-1:0]    cnt;
        logic [7:0]       mem;
    } t_slot_rec;

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_CHECK, S_SLOT, S_GSEL, S_GCHK, S_GNEXT,
        S_SCAN, S_UPD, S_WRITE, S_SYS1, S_SYS2, S_DONE
    } t_fsm;

    // configuration
    logic [2:0] r_numa_count;
    logic [3:0] r_gpn;
    logic [5:0] r_cpg;
    logic       r_smt_on;
    logic       r_smt_protect;
    logic [7:0] r_mem_per_group;

    t_fsm              r_state;
    logic [CLRW-1:0]   r_clr;
    logic              r_op;
    logic              r_kind;
    logic [KB-1:0]     r_key;
    logic [8:0]        r_ask;
    logic [7:0]        r_mem;
    t_status           r_status;
    logic [SW-1:0]     r_slot;
    logic [SW:0]       r_sa;
    logic              r_spv;
    logic [SW-1:0]     r_sp;
    logic [NW-1:0]     r_n;
    logic [NW:0]       r_i;
    logic [JW-1:0]     r_j;
    logic [NW-1:0]     r_start;
    logic [GW-1:0]     r_g;
    logic [CAW-1:0]    r_base;
    logic [VW-1:0]     r_rk;
    logic              r_pv;
    logic [KW-1:0]     r_pk;
    logic [VW-1:0]     r_len;
    logic [KW-1:0]     r_runk;
    logic [VW-1:0]     r_wc;
    t_slot_rec         r_rec;
    logic [SYW-1:0]    r_sys1;
    logic [10:0]       r_sys;

    logic              r_ovalid;
    logic [3:0]        r_o_status;
    logic [7:0]        r_o_slot;
    logic [10:0]       r_o_first;
    logic [6:0]        r_o_cnt;

    logic [7:0]        r_used [TOTAL_GROUPS];
    logic [6:0]        r_idle [TOTAL_GROUPS];

    t_core_state       r_core_mem [TOTAL_CORES];
    t_core_state       r_core_rd;
    t_slot_rec         r_slot_mem [SLOT_COUNT];
    t_slot_rec         r_slot_rd;

    logic              core_we;
    logic [CAW-1:0]    core_addr;
    t_core_state       core_wdata;
    logic              slot_we;
    logic [SW-1:0]     slot_addr;
    t_slot_rec         slot_wdata;

    logic [3:0]        eff_numa;
    logic [4:0]        eff_gpn;
    logic [6:0]        raw_vis;
    logic [VW-1:0]     vis;
    logic [NW-1:0]     n_next;
    logic [VW-1:0]     len_new;
    logic [KW-1:0]     run_k;
    logic [GW-1:0]     g_sel;
    logic [CAW-1:0]    base_sel;
    logic              slot_hit;
    logic              grp_ok;
    logic [8:0]        used_add;
    logic [7:0]        used_sub;
    logic [7:0]        idle_add;
    logic [PW-1:0]     sys_prod;
    logic              res_ok;
    t_slot_rec         upd_rec;

    // ---------------- derived values ----------------
    assign eff_numa = (r_numa_count > MAX_NUMA) ? 4'(MAX_NUMA) : {1'b0, r_numa_count};
    assign eff_gpn  = (r_gpn > MAX_GROUPS_PER_NUMA) ? 5'(MAX_GROUPS_PER_NUMA)
                                                    : {1'b0, r_gpn};
    assign raw_vis  = r_smt_on ? {r_cpg, 1'b0} : {1'b0, r_cpg};
    assign vis      = (raw_vis > MAX_CORES_PER_GROUP) ? VW'(MAX_CORES_PER_GROUP)
                                                      : VW'(raw_vis);
    assign n_next   = (5'(r_n) + 5'd1 >= 5'(eff_numa)) ? '0 : NW'(r_n + 1'b1);
    assign len_new  = VW'(r_len + 1'b1);
    assign run_k    = (r_len == '0) ? r_pk : r_runk;
    assign g_sel    = GW'(int'(r_n) * MAX_GROUPS_PER_NUMA + int'(r_j));
    assign base_sel = CAW'((int'(r_n) * MAX_GROUPS_PER_NUMA + int'(r_j))
                           * MAX_CORES_PER_GROUP);
    assign slot_hit = (r_op == OP_RELEASE)
                    ? ((r_slot_rd.kind != SLOT_FREE) && (r_slot_rd.key == r_key))
                    : (r_slot_rd.kind == SLOT_FREE);
    assign grp_ok   = (eff_gpn != 5'd0)
                   && ({1'b0, r_mem} + {1'b0, r_used[r_g]} <= {1'b0, r_mem_per_group})
                   && (r_ask <= {2'b00, r_idle[r_g]});
    assign used_add = {1'b0, r_used[r_g]} + {1'b0, r_mem};
    assign used_sub = (r_used[r_g] > r_rec.mem) ? (r_used[r_g] - r_rec.mem) : 8'd0;
    assign idle_add = 8'(r_idle[r_g]) + 8'(r_rec.cnt);
    assign sys_prod = PW'(r_sys1) * PW'(vis) + PW'(r_rec.k);
    assign res_ok   = (r_status == ST_GRANTED) || (r_status == ST_RELEASED)
                   || (r_status == ST_RES_KEPT);

    always_comb begin
        upd_rec = r_rec;
        if (r_op == OP_RELEASE) begin
            upd_rec.kind = SLOT_FREE;
        end
    end

    // ---------------- memory port control ----------------
    always_comb begin
        core_we    = 1'b0;
        core_addr  = CAW'(r_base + CAW'(r_rk));
        core_wdata = CORE_IDLE;
        slot_we    = 1'b0;
        slot_addr  = SW'(r_sa);
        slot_wdata = r_rec;
        unique case (r_state)
            S_CLEAR: begin
                core_we    = (r_clr < TOTAL_CORES);
                core_addr  = CAW'(r_clr);
                slot_we    = (r_clr < SLOT_COUNT);
                slot_addr  = SW'(r_clr);
                slot_wdata = '0;
            end
            S_UPD: begin
                slot_we    = 1'b1;
                slot_addr  = r_slot;
                slot_wdata = upd_rec;
            end
            S_WRITE: begin
                core_we   = (r_wc < r_rec.cnt);
                core_addr = CAW'(r_base + CAW'(r_rec.k) + CAW'(r_wc));
                if (r_op == OP_RELEASE) begin
                    core_wdata = CORE_IDLE;
                end else if (r_kind == KIND_RESERVE) begin
                    core_wdata = CORE_RESERVED;
                end else begin
                    core_wdata = CORE_EXCL;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (core_we) begin
            r_core_mem[core_addr] <= core_wdata;
        end
        r_core_rd <= r_core_mem[core_addr];
    end

    always_ff @(posedge i_clk) begin
        if (slot_we) begin
            r_slot_mem[slot_addr] <= slot_wdata;
        end
        r_slot_rd <= r_slot_mem[slot_addr];
    end

    // ---------------- sequencer ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state         <= S_CLEAR;
            r_clr           <= '0;
            r_ovalid        <= 1'b0;
            r_numa_count    <= RST_NUMA_COUNT;
            r_gpn           <= RST_GROUPS_PER_NUMA;
            r_cpg           <= RST_CORES_PER_GROUP;
            r_smt_on        <= RST_SMT_ON;
            r_smt_protect   <= RST_SMT_PROTECT;
            r_mem_per_group <= RST_MEMORY_PER_GROUP;
            r_start         <= '0;
        end else begin
            if (r_ovalid && m_axis_tready) begin
                r_ovalid <= 1'b0;
            end

            unique case (r_state)
                S_CLEAR: begin
                    for (int g = 0; g < TOTAL_GROUPS; g++) begin
                        r_used[g] <= 8'd0;
                        r_idle[g] <= 7'(vis);
                    end
                    r_start <= '0;
                    r_clr   <= CLRW'(r_clr + 1'b1);
                    if (r_clr == CLRW'(CLR_N - 1)) begin
                        r_state <= S_IDLE;
                    end
                end

                S_IDLE: begin
                    if (s_axis_tvalid) begin
                        r_op   <= s_axis_tuser[0];
                        r_kind <= s_axis_tuser[1];
                        r_key  <= s_axis_tdata[KB-1:0];
                        r_ask  <= {1'b0, s_axis_tdata[71:64]};
                        r_mem  <= s_axis_tdata[79:72];
                        r_sa   <= '0;
                        r_spv  <= 1'b0;
                        r_state <= (s_axis_tuser[0] == OP_RELEASE) ? S_SLOT : S_CHECK;
                    end
                end

                S_CHECK: begin
                    priority if (r_kind == KIND_EXCL && r_ask > SHARED_LIMIT) begin
                        r_status <= ST_SHARED;
                        r_state  <= S_DONE;
                    end else if (r_kind == KIND_EXCL && r_ask > raw_vis) begin
                        r_status <= ST_TOO_MANY;
                        r_state  <= S_DONE;
                    end else if (r_kind == KIND_EXCL && r_mem >= r_mem_per_group) begin
                        r_status <= ST_MEM_BIG;
                        r_state  <= S_DONE;
                    end else begin
                        if (r_smt_protect && r_smt_on && ((r_ask[7:0] & ODD_BIT) != 8'd0))
                        begin
                            r_ask <= r_ask + 9'd1;
                        end
                        r_state <= S_SLOT;
                    end
                end

                // one slot read per cycle, compared once the read data is registered
                S_SLOT: begin
                    if (r_sa < SLOT_COUNT) begin
                        r_sa  <= r_sa + 1'b1;
                        r_spv <= 1'b1;
                        r_sp  <= SW'(r_sa);
                    end else begin
                        r_spv <= 1'b0;
                    end
                    if (r_spv && slot_hit) begin
                        r_slot <= r_sp;
                        if (r_op == OP_RELEASE) begin
                            r_rec <= r_slot_rd;
                            r_n   <= r_slot_rd.n;
                            r_j   <= r_slot_rd.j;
                            r_ask <= 9'(r_slot_rd.cnt);
                            if (r_slot_rd.kind == SLOT_RSVD) begin
                                r_status <= ST_RES_KEPT;
                                r_state  <= S_SYS1;
                            end else begin
                                r_status <= ST_RELEASED;
                                r_state  <= S_GSEL;
                            end
                        end else if (eff_numa == 4'd0) begin
                            r_status <= ST_NO_FIT;
                            r_state  <= S_DONE;
                        end else begin
                            r_n     <= r_start;
                            r_i     <= '0;
                            r_j     <= '0;
                            r_state <= S_GSEL;
                        end
                    end else if (!r_spv && r_sa >= SLOT_COUNT) begin
                        r_status <= (r_op == OP_RELEASE) ? ST_NOT_FOUND : ST_NO_SLOT;
                        r_state  <= S_DONE;
                    end
                end

                S_GSEL: begin
                    r_g     <= g_sel;
                    r_base  <= base_sel;
                    r_state <= (r_op == OP_RELEASE) ? S_UPD : S_GCHK;
                end

                S_GCHK: begin
                    r_rk  <= '0;
                    r_pv  <= 1'b0;
                    r_len <= '0;
                    r_state <= grp_ok ? S_SCAN : S_GNEXT;
                end

                S_GNEXT: begin
                    if (5'(r_j) + 5'd1 < eff_gpn) begin
                        r_j     <= JW'(r_j + 1'b1);
                        r_state <= S_GSEL;
                    end else begin
                        // node done: the start pointer follows every node searched
                        r_start <= n_next;
                        r_n     <= n_next;
                        r_j     <= '0;
                        if (5'(r_i) + 5'd1 < 5'(eff_numa)) begin
                            r_i     <= r_i + 1'b1;
                            r_state <= S_GSEL;
                        end else begin
                            r_status <= ST_NO_FIT;
                            r_state  <= S_DONE;
                        end
                    end
                end

                // core scan: first run of idle cores long enough for the ask
                S_SCAN: begin
                    if (r_rk < vis) begin
                        r_rk <= r_rk + 1'b1;
                        r_pv <= 1'b1;
                        r_pk <= KW'(r_rk);
                    end else begin
                        r_pv <= 1'b0;
                    end
                    if (r_pv) begin
                        if (r_core_rd == CORE_IDLE) begin
                            r_runk <= run_k;
                            r_len  <= len_new;
                            if (len_new >= r_ask) begin
                                r_rec.kind <= (r_kind == KIND_RESERVE) ? SLOT_RSVD : SLOT_EXCL;
                                r_rec.key  <= r_key;
                                r_rec.n    <= r_n;
                                r_rec.j    <= r_j;
                                r_rec.k    <= run_k;
                                r_rec.cnt  <= VW'(r_ask);
                                r_rec.mem  <= r_mem;
                                r_start    <= n_next;
                                r_status   <= ST_GRANTED;
                                r_state    <= S_UPD;
                            end
                        end else begin
                            r_len <= '0;
                        end
                    end else if (r_rk >= vis) begin
                        r_state <= S_GNEXT;
                    end
                end

                S_UPD: begin
                    if (r_op == OP_RELEASE) begin
                        r_used[r_g] <= used_sub;
                        r_idle[r_g] <= (idle_add > 8'd127) ? 7'd127 : 7'(idle_add);
                    end else begin
                        r_used[r_g] <= used_add[8] ? 8'hFF : used_add[7:0];
                        r_idle[r_g] <= 7'(r_idle[r_g] - 7'(r_ask));
                    end
                    r_wc    <= '0;
                    r_state <= S_WRITE;
                end

                S_WRITE: begin
                    if (r_wc < r_rec.cnt) begin
                        r_wc <= r_wc + 1'b1;
                    end else begin
                        r_state <= S_SYS1;
                    end
                end

                S_SYS1: begin
                    r_sys1  <= SYW'(SYW'(r_n) * SYW'(eff_gpn) + SYW'(r_j));
                    r_state <= S_SYS2;
                end

                S_SYS2: begin
                    r_sys   <= 11'(sys_prod);
                    r_state <= S_DONE;
                end

                S_DONE: begin
                    if (!r_ovalid || m_axis_tready) begin
                        r_ovalid   <= 1'b1;
                        r_o_status <= r_status;
                        r_o_slot   <= res_ok ? 8'(r_slot) : 8'd0;
                        r_o_first  <= res_ok ? r_sys : 11'd0;
                        r_o_cnt    <= res_ok ? 7'(r_ask) : 7'd0;
                        r_state    <= S_IDLE;
                    end
                end

                default: r_state <= S_CLEAR;
            endcase

            // geometry writes restart the clearing pass
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    REG_NUMA_COUNT: begin
                        r_numa_count <= i_cfg_wdata[2:0];
                        r_state      <= S_CLEAR;
                        r_clr        <= '0;
                    end
                    REG_GROUPS_PER_NUMA: begin
                        r_gpn   <= i_cfg_wdata[3:0];
                        r_state <= S_CLEAR;
                        r_clr   <= '0;
                    end
                    REG_CORES_PER_GROUP: begin
                        r_cpg   <= i_cfg_wdata[5:0];
                        r_state <= S_CLEAR;
                        r_clr   <= '0;
                    end
                    REG_SMT_ON: begin
                        r_smt_on <= i_cfg_wdata[0];
                        r_state  <= S_CLEAR;
                        r_clr    <= '0;
                    end
                    REG_SMT_PROTECT:      r_smt_protect   <= i_cfg_wdata[0];
                    REG_MEMORY_PER_GROUP: r_mem_per_group <= i_cfg_wdata;
                    default: ;
                endcase
            end
        end
    end

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = {6'd0, r_o_cnt, r_o_first, r_o_slot};
    assign m_axis_tuser  = r_o_status;

endmodule

/* hdl/cca_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cca_checker
// Port-level checks on the contiguous core allocator, bound to the top level.
// ----------------------------------------------------------------------------
`include "contiguous_core_allocator_defines.svh"

module cca_checker
    import cca_pkg::*;
(
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  s_axis_tvalid,
    input logic                  s_axis_tready,
    input logic [79:0]           s_axis_tdata,
    input logic [1:0]            s_axis_tuser,
    input logic                  m_axis_tvalid,
    input logic                  m_axis_tready,
    input logic [31:0]           m_axis_tdata,
    input logic [3:0]            m_axis_tuser,
    input logic                  i_cfg_we,
    input logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input logic [CFG_DATA_W-1:0] i_cfg_wdata
);

    // a refused or unmatched word carries no slot, core or count
    `CCA_ASSERT_NOW(a_refusal_empty, i_clk, i_rst_n, m_axis_tvalid && (m_axis_tuser == ST_TOO_MANY || m_axis_tuser == ST_MEM_BIG || m_axis_tuser == ST_NO_SLOT || m_axis_tuser == ST_NO_FIT || m_axis_tuser == ST_NOT_FOUND || m_axis_tuser == ST_SHARED), m_axis_tdata[25:0] == 26'd0, "refusal carries payload")

    // one word in flight at a time
    `CCA_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, s_axis_tvalid && s_axis_tready, !s_axis_tready, "input taken while busy")

    // a geometry write starts the clearing pass
    `CCA_ASSERT_NEXT(a_clear_after_geom, i_clk, i_rst_n, i_cfg_we && (i_cfg_idx == REG_NUMA_COUNT || i_cfg_idx == REG_GROUPS_PER_NUMA || i_cfg_idx == REG_CORES_PER_GROUP || i_cfg_idx == REG_SMT_ON), !s_axis_tready, "ready during clearing pass")

    `CCA_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "stalled output word changed")

endmodule

bind contiguous_core_allocator cca_checker u_cca_checker (.*);

/* bench/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the contiguous core allocator. A table of directed
// words is followed by random requests and releases over several register
// settings. Every result word is checked, against the table's values or a local
// model of the slot, core and group state, with random stalls on both stream sides.
// ----------------------------------------------------------------------------
module tb_top;
    import cca_pkg::*;

    localparam int TOT_GROUPS = CCA_MAX_NUMA * CCA_MAX_GROUPS_PER_NUMA;
    localparam int TOT_CORES  = TOT_GROUPS * CCA_MAX_CORES_PER_GROUP;
    localparam int IDLE_LIMIT = 20000;

    typedef struct packed {
        t_status     status;
        logic [7:0]  slot;
        logic [10:0] first;
        logic [6:0]  count;
    } alloc_res_t;

    typedef struct {
        logic        op;
        logic        kind;
        logic [63:0] key;
        logic [7:0]  ask;
        logic [7:0]  mem;
        bit          typed;
        alloc_res_t  want;
    } dir_row_t;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [79:0]           s_axis_tdata = '0;
    logic [1:0]            s_axis_tuser = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b1;
    logic [31:0]           m_axis_tdata;
    logic [3:0]            m_axis_tuser;
    logic                  i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx = '0;
    logic [CFG_DATA_W-1:0] i_cfg_wdata = '0;

    contiguous_core_allocator uut (.*);

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // model registers and state
    int cf_numa, cf_gpn, cf_cpg, cf_smt, cf_prot, cf_mem;
    int core_st [TOT_CORES];
    int grp_mem [TOT_GROUPS];
    int grp_idle [TOT_GROUPS];
    t_slot_kind slot_kd [CCA_SLOT_COUNT];
    logic [63:0] slot_ky [CCA_SLOT_COUNT];
    int slot_loc [CCA_SLOT_COUNT];
    int slot_cnt [CCA_SLOT_COUNT];
    int slot_gb [CCA_SLOT_COUNT];
    int numa_start;

    alloc_res_t grant_q [$];
    int  errors = 0;
    bit  quiet = 1'b0;
    int  idle_cycles = 0;
    int  stall = 0;

    function automatic int eff_numa();
        return cf_numa > CCA_MAX_NUMA ? CCA_MAX_NUMA : cf_numa;
    endfunction

    function automatic int eff_gpn();
        return cf_gpn > CCA_MAX_GROUPS_PER_NUMA ? CCA_MAX_GROUPS_PER_NUMA : cf_gpn;
    endfunction

    function automatic int vis_cores();
        int v;
        v = cf_cpg * (cf_smt ? 2 : 1);
        return v > CCA_MAX_CORES_PER_GROUP ? CCA_MAX_CORES_PER_GROUP : v;
    endfunction

    function automatic void clear_alloc();
        for (int c = 0; c < TOT_CORES; c++) core_st[c] = CORE_IDLE;
        for (int g = 0; g < TOT_GROUPS; g++) begin
            grp_mem[g] = 0;
            grp_idle[g] = vis_cores();
        end
        for (int s = 0; s < CCA_SLOT_COUNT; s++) begin
            slot_kd[s] = SLOT_FREE;
            slot_ky[s] = '0;
            slot_loc[s] = 0;
            slot_cnt[s] = 0;
            slot_gb[s] = 0;
        end
        numa_start = 0;
    endfunction

    function automatic logic [10:0] sys_index(int loc);
        int g, k;
        g = (loc / CCA_MAX_CORES_PER_GROUP) % TOT_GROUPS;
        k = loc % CCA_MAX_CORES_PER_GROUP;
        return 11'(((g / CCA_MAX_GROUPS_PER_NUMA) * eff_gpn() + g % CCA_MAX_GROUPS_PER_NUMA)
                   * vis_cores() + k);
    endfunction

    // round robin over nodes, first group with memory and a long enough idle run
    function automatic bit find_run(int count, int mem, output int loc);
        int ncnt, n, vis, base, l;
        bit done;
        ncnt = eff_numa();
        vis = vis_cores();
        done = 1'b0;
        loc = 0;
        if (ncnt == 0) return 1'b0;
        n = numa_start % ncnt;
        for (int i = 0; i < ncnt && !done; i++) begin
            for (int j = 0; j < eff_gpn() && !done; j++) begin
                base = (n * CCA_MAX_GROUPS_PER_NUMA + j);
                if (mem > cf_mem - grp_mem[base]) continue;
                if (count > grp_idle[base]) continue;
                for (int k = 0; k < vis && !done; k++) begin
                    if (core_st[base * CCA_MAX_CORES_PER_GROUP + k] != CORE_IDLE) continue;
                    l = k;
                    while (l < vis && core_st[base * CCA_MAX_CORES_PER_GROUP + l] == CORE_IDLE)
                        l++;
                    if (l - k >= count) begin
                        loc = base * CCA_MAX_CORES_PER_GROUP + k;
                        done = 1'b1;
                    end
                end
            end
            n = (n + 1) % ncnt;
            numa_start = n;
        end
        return done;
    endfunction

    function automatic alloc_res_t predict_alloc(logic op, logic kind, logic [63:0] key,
                                                 logic [7:0] ask_in, logic [7:0] mem);
        alloc_res_t r;
        int s, loc, g, ask, lim;
        r = '0;
        r.status = ST_GRANTED;
        if (op == OP_RELEASE) begin
            r.status = ST_NOT_FOUND;
            s = -1;
            // free slots are skipped, lowest match wins
            for (int i = 0; i < CCA_SLOT_COUNT; i++)
                if (s < 0 && slot_kd[i] != SLOT_FREE && slot_ky[i] == key) s = i;
            if (s >= 0) begin
                loc = slot_loc[s] % TOT_CORES;
                g = loc / CCA_MAX_CORES_PER_GROUP;
                r.slot = 8'(s);
                r.first = sys_index(loc);
                r.count = 7'(slot_cnt[s]);
                if (slot_kd[s] == SLOT_RSVD) begin
                    r.status = ST_RES_KEPT;
                end else begin
                    r.status = ST_RELEASED;
                    grp_mem[g] = grp_mem[g] > slot_gb[s] ? grp_mem[g] - slot_gb[s] : 0;
                    for (int c = 0; c < slot_cnt[s]; c++) begin
                        if (loc + c < TOT_CORES) core_st[loc + c] = CORE_IDLE;
                        if (grp_idle[g] < 127) grp_idle[g]++;
                    end
                    slot_kd[s] = SLOT_FREE;
                end
            end
            return r;
        end
        ask = ask_in;
        lim = cf_cpg * (cf_smt ? 2 : 1);
        if (kind == KIND_EXCL && ask_in > SHARED_LIMIT) r.status = ST_SHARED;
        else if (kind == KIND_EXCL && ask > lim) r.status = ST_TOO_MANY;
        else if (kind == KIND_EXCL && mem >= cf_mem) r.status = ST_MEM_BIG;
        else begin
            if (cf_prot && cf_smt && (ask_in & ODD_BIT)) ask++;
            s = 0;
            while (s < CCA_SLOT_COUNT && slot_kd[s] != SLOT_FREE) s++;
            if (s >= CCA_SLOT_COUNT) r.status = ST_NO_SLOT;
            else if (!find_run(ask, mem, loc)) r.status = ST_NO_FIT;
            else begin
                g = loc / CCA_MAX_CORES_PER_GROUP;
                grp_mem[g] = grp_mem[g] + mem > 255 ? 255 : grp_mem[g] + mem;
                grp_idle[g] = grp_idle[g] - ask;
                for (int c = 0; c < ask; c++)
                    core_st[loc + c] = (kind == KIND_RESERVE) ? CORE_RESERVED : CORE_EXCL;
                slot_kd[s] = (kind == KIND_RESERVE) ? SLOT_RSVD : SLOT_EXCL;
                slot_ky[s] = key;
                slot_loc[s] = loc;
                slot_cnt[s] = ask;
                slot_gb[s] = mem;
                r.slot = 8'(s);
                r.first = sys_index(loc);
                r.count = 7'(ask);
            end
        end
        return r;
    endfunction

    task automatic report_miss(string what, int got, int want);
        $display("MISS %s: got %0d want %0d at %0t", what, got, want, $realtime);
        errors++;
    endtask

    // result side: random stall bursts unless quiet
    always @(negedge i_clk) begin
        if (stall > 0) begin
            stall--;
            m_axis_tready <= 1'b0;
        end else if (!quiet && $urandom_range(0, 7) == 0) begin
            stall = $urandom_range(1, 10) - 1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        alloc_res_t w;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (grant_q.size() == 0) begin
                report_miss("unexpected word", m_axis_tuser, -1);
            end else begin
                w = grant_q.pop_front();
                if (m_axis_tuser != w.status) report_miss("status", m_axis_tuser, w.status);
                if (m_axis_tdata[7:0] != w.slot) report_miss("pod_slot", m_axis_tdata[7:0], w.slot);
                if (m_axis_tdata[18:8] != w.first)
                    report_miss("first_core", m_axis_tdata[18:8], w.first);
                if (m_axis_tdata[25:19] != w.count)
                    report_miss("core_count", m_axis_tdata[25:19], w.count);
            end
        end
    end

    // watchdog on cycles with no word moving either way
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || i_cfg_we)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles == IDLE_LIMIT) begin
            $display("contiguous_core_allocator: mismatch");
            $finish;
        end
    end

    task automatic send_word(logic op, logic kind, logic [63:0] key, logic [7:0] ask,
                             logic [7:0] mem, bit typed, alloc_res_t want);
        alloc_res_t p;
        @(negedge i_clk);
        if (!quiet && $urandom_range(0, 3) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {mem, ask, key};
        s_axis_tuser  <= {kind, op};
        do @(posedge i_clk); while (!s_axis_tready);
        p = predict_alloc(op, kind, key, ask, mem);
        grant_q.push_back(typed ? want : p);
    endtask

    task automatic drain();
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (grant_q.size() != 0) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [7:0] val);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_wdata <= val;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            REG_NUMA_COUNT:       begin cf_numa = val & 7;  clear_alloc(); end
            REG_GROUPS_PER_NUMA:  begin cf_gpn = val & 15;  clear_alloc(); end
            REG_CORES_PER_GROUP:  begin cf_cpg = val & 63;  clear_alloc(); end
            REG_SMT_ON:           begin cf_smt = val & 1;   clear_alloc(); end
            REG_SMT_PROTECT:      cf_prot = val & 1;
            REG_MEMORY_PER_GROUP: cf_mem = val;
            default: ;
        endcase
    endtask

    task automatic random_word();
        logic [63:0] key;
        logic [7:0]  ask, mem;
        int amax;
        key = ($urandom_range(0, 9) < 7) ? 64'($urandom_range(0, 31)) : {$urandom, $urandom};
        amax = vis_cores() > 24 ? 24 : vis_cores();
        ask = ($urandom_range(0, 9) < 7) ? 8'($urandom_range(0, amax)) : 8'($urandom);
        mem = ($urandom_range(0, 9) < 7) ? 8'($urandom_range(0, cf_mem / 4)) : 8'($urandom);
        if ($urandom_range(0, 9) < 4)
            send_word(OP_RELEASE, 1'($urandom), key, 8'($urandom), 8'($urandom), 1'b0, '0);
        else
            send_word(OP_REQUEST, ($urandom_range(0, 4) == 0) ? KIND_RESERVE : KIND_EXCL,
                      key, ask, mem, 1'b0, '0);
    endtask

    dir_row_t rows [$];

    task automatic add_row(logic op, logic kind, logic [63:0] key, logic [7:0] ask,
                           logic [7:0] mem, bit typed, t_status st, int slot, int first,
                           int cnt);
        dir_row_t r;
        r.op = op; r.kind = kind; r.key = key; r.ask = ask; r.mem = mem; r.typed = typed;
        r.want = '{st, 8'(slot), 11'(first), 7'(cnt)};
        rows.push_back(r);
    endtask

    // numa, groups, cores, smt, protect, memory per phase
    logic [7:0] phase_cfg [7][6] = '{
        '{8'd2, 8'd4,  8'd8,  8'd1,  8'd0,  8'd64},
        '{8'd1, 8'd1,  8'd1,  8'd0,  8'd0,  8'd1},
        '{8'd4, 8'd8,  8'd32, 8'd1,  8'd1,  8'd255},
        '{8'd0, 8'd3,  8'd5,  8'd0,  8'd1,  8'd10},
        '{8'd7, 8'd15, 8'd63, 8'hFF, 8'hFF, 8'd200},
        '{8'd3, 8'd2,  8'd12, 8'd1,  8'd1,  8'd0},
        '{8'd2, 8'd5,  8'd3,  8'd1,  8'd0,  8'd40}
    };

    initial begin
        cf_numa = RST_NUMA_COUNT; cf_gpn = RST_GROUPS_PER_NUMA; cf_cpg = RST_CORES_PER_GROUP;
        cf_smt = RST_SMT_ON; cf_prot = RST_SMT_PROTECT; cf_mem = RST_MEMORY_PER_GROUP;
        clear_alloc();
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        add_row(OP_REQUEST, KIND_EXCL, 64'd1, 8'd4, 8'd8, 1, ST_GRANTED, 0, 0, 4);
        add_row(OP_RELEASE, KIND_EXCL, 64'd1, 8'd0, 8'd0, 1, ST_RELEASED, 0, 0, 4);
        add_row(OP_RELEASE, KIND_EXCL, 64'd99, 8'd0, 8'd0, 1, ST_NOT_FOUND, 0, 0, 0);
        add_row(OP_REQUEST, KIND_EXCL, 64'd2, 8'd25, 8'd0, 1, ST_SHARED, 0, 0, 0);
        add_row(OP_REQUEST, KIND_EXCL, 64'd2, 8'd17, 8'd0, 1, ST_TOO_MANY, 0, 0, 0);
        add_row(OP_REQUEST, KIND_EXCL, 64'd2, 8'd4, 8'd64, 1, ST_MEM_BIG, 0, 0, 0);
        // reservation skips the limits but can never fit
        add_row(OP_REQUEST, KIND_RESERVE, 64'd3, 8'hFF, 8'hFF, 1, ST_NO_FIT, 0, 0, 0);
        add_row(OP_REQUEST, KIND_RESERVE, 64'd7, 8'd2, 8'd0, 0, ST_GRANTED, 0, 0, 0);
        add_row(OP_RELEASE, KIND_EXCL, 64'd7, 8'd0, 8'd0, 0, ST_GRANTED, 0, 0, 0);
        add_row(OP_REQUEST, KIND_EXCL, 64'd0, 8'd0, 8'd0, 0, ST_GRANTED, 0, 0, 0);
        add_row(OP_REQUEST, KIND_EXCL, '1, 8'd16, 8'd63, 0, ST_GRANTED, 0, 0, 0);
        add_row(OP_REQUEST, KIND_EXCL, 64'd5, 8'd3, 8'd1, 0, ST_GRANTED, 0, 0, 0);
        add_row(OP_RELEASE, KIND_RESERVE, '1, 8'hFF, 8'hFF, 0, ST_GRANTED, 0, 0, 0);
        add_row(OP_RELEASE, KIND_EXCL, 64'd0, 8'd0, 8'd0, 0, ST_GRANTED, 0, 0, 0);
        foreach (rows[i])
            send_word(rows[i].op, rows[i].kind, rows[i].key, rows[i].ask, rows[i].mem,
                      rows[i].typed, rows[i].want);

        // odd ask padded once protection is on
        drain();
        write_reg(REG_SMT_PROTECT, 8'd1);
        send_word(OP_REQUEST, KIND_EXCL, 64'd11, 8'd3, 8'd2, 0, '0);
        send_word(OP_REQUEST, KIND_EXCL, 64'd12, 8'd1, 8'd2, 0, '0);
        drain();
        write_reg(3'd6, 8'hFF);
        write_reg(3'd7, 8'hFF);

        for (int ph = 0; ph < 7; ph++) begin
            drain();
            quiet = (ph == 6);
            for (int r = 0; r < 6; r++) write_reg(CFG_IDX_W'(r), phase_cfg[ph][r]);
            if (ph == 0) begin
                // zero-core grants fill every slot, then one more finds none
                for (int i = 0; i < CCA_SLOT_COUNT; i++)
                    send_word(OP_REQUEST, KIND_EXCL, 64'(1000 + i), 8'd0, 8'd0, 0, '0);
                send_word(OP_REQUEST, KIND_EXCL, 64'd77, 8'd2, 8'd0, 1,
                          '{ST_NO_SLOT, 8'd0, 11'd0, 7'd0});
                send_word(OP_RELEASE, KIND_EXCL, 64'd1005, 8'd0, 8'd0, 0, '0);
            end
            for (int i = 0; i < 20; i++) begin
                if (i == 10) begin
                    drain();
                    write_reg(REG_MEMORY_PER_GROUP, 8'($urandom));
                end
                random_word();
            end
        end

        drain();
        repeat (50) @(posedge i_clk);
        if (errors == 0)
            $display("contiguous_core_allocator: match");
        else
            $display("contiguous_core_allocator: mismatch");
        $finish;
    end

endmodule
